// ----- rtl/ac62_pkg.sv -----
// Shared types, constants and character functions for the alnum62 cipher core.
// Used by every module of the block; no dependencies of its own.

package ac62_pkg;

    // default number of key table words
    localparam int unsigned KEY_DEPTH_DEF = 64;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QAW         = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCW         = $clog2(QUEUE_DEPTH + 1);

    // alphabet and character codes
    localparam logic [6:0] ALPHA_SIZE  = 7'd62;
    localparam logic [6:0] ALPHA_TWICE = 7'd124;
    localparam logic [5:0] UPPER_BASE  = 6'd26;
    localparam logic [5:0] DIGIT_BASE  = 6'd52;
    localparam logic [7:0] CH_LOWER_A  = 8'd97;
    localparam logic [7:0] CH_LOWER_Z  = 8'd122;
    localparam logic [7:0] CH_UPPER_A  = 8'd65;
    localparam logic [7:0] CH_UPPER_Z  = 8'd90;
    localparam logic [7:0] CH_DIGIT_0  = 8'd48;
    localparam logic [7:0] CH_DIGIT_9  = 8'd57;
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_SPACE    = 8'd32;

    typedef enum logic {
        KIND_KEY  = 1'b0,
        KIND_DATA = 1'b1
    } t_kind;

    typedef enum logic {
        DIR_ENCRYPT = 1'b0,
        DIR_DECRYPT = 1'b1
    } t_dir;

    typedef enum logic {
        REG_DIRECTION  = 1'b0,
        REG_KEY_LENGTH = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_dir       direction;
        logic [6:0] key_length;
    } t_cfg;

    // one classified data item on its way to the back end
    typedef struct packed {
        logic [7:0] data_byte;
        logic       blank;
        logic [5:0] sym;
        logic [6:0] key;
    } t_entry;

    // whitespace: tab through carriage return, and space
    function automatic logic f_is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // character code to alphabet index, anything else to zero
    function automatic logic [5:0] f_sym_index(input logic [7:0] b);
        logic [5:0] idx;
        idx = '0;
        if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
            idx = 6'(b - CH_LOWER_A);
        end else if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
            idx = 6'(b - CH_UPPER_A) + UPPER_BASE;
        end else if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
            idx = 6'(b - CH_DIGIT_0) + DIGIT_BASE;
        end
        return idx;
    endfunction

    // alphabet index to character code
    function automatic logic [7:0] f_sym_char(input logic [5:0] idx);
        logic [7:0] c;
        if (idx < UPPER_BASE) begin
            c = CH_LOWER_A + 8'(idx);
        end else if (idx < DIGIT_BASE) begin
            c = CH_UPPER_A + 8'(idx - UPPER_BASE);
        end else begin
            c = CH_DIGIT_0 + 8'(idx - DIGIT_BASE);
        end
        return c;
    endfunction

endpackage

// ----- rtl/ac62_front.sv -----
// Front end: accepts items, writes key loads into the key table, tracks the
// key position and classifies data bytes. Depends on ac62_pkg.

module ac62_front #(
    parameter int unsigned KEY_DEPTH = ac62_pkg::KEY_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ac62_pkg::t_cfg            i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  ac62_pkg::t_kind           i_kind,
    input  logic [5:0]                i_key_index,
    input  logic [6:0]                i_key_value,
    input  logic [7:0]                i_in_byte,
    input  logic [ac62_pkg::QCW-1:0]  i_q_count,
    output logic                      o_valid,
    output ac62_pkg::t_entry          o_entry
);
    import ac62_pkg::*;

    localparam int unsigned AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int unsigned LW = (AW + 1 > 7) ? AW + 1 : 7;

    logic [6:0]    r_key_mem [KEY_DEPTH];
    logic [AW-1:0] r_pos;
    logic [AW-1:0] n_pos;
    logic          r_valid;
    logic [7:0]    r_data_byte;
    logic          r_blank;
    logic [5:0]    r_sym;
    logic [6:0]    r_key;

    logic          accept;
    logic          key_load;
    logic          data_take;
    logic          slot_ok;
    logic [LW-1:0] len_req;
    logic [LW-1:0] eff_len;

    // room for this item and the one already in flight
    assign o_ready   = (3'(i_q_count) + 3'(r_valid)) < 3'(QUEUE_DEPTH);
    assign accept    = i_valid && o_ready;
    assign key_load  = accept && (i_kind == KIND_KEY);
    assign data_take = accept && (i_kind == KIND_DATA);
    assign slot_ok   = 32'(i_key_index) < KEY_DEPTH;

    // effective key length: zero acts as one, clipped to the table
    always_comb begin
        len_req = (i_cfg.key_length == '0) ? LW'(1) : LW'(i_cfg.key_length);
        eff_len = (len_req > LW'(KEY_DEPTH)) ? LW'(KEY_DEPTH) : len_req;
    end

    // key position update
    always_comb begin
        n_pos = r_pos;
        if (key_load) begin
            n_pos = '0;
        end else if (data_take) begin
            if (LW'(r_pos) + LW'(1) >= eff_len) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + AW'(1);
            end
        end
    end

    // key table write and registered read
    always_ff @(posedge i_clk) begin
        if (key_load && slot_ok) begin
            r_key_mem[AW'(i_key_index)] <= i_key_value;
        end
        if (data_take) begin
            r_key <= r_key_mem[r_pos];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_valid <= data_take;
        end
    end

    // classified payload
    always_ff @(posedge i_clk) begin
        if (data_take) begin
            r_data_byte <= i_in_byte;
            r_blank     <= f_is_blank(i_in_byte);
            r_sym       <= f_sym_index(i_in_byte);
        end
    end

    assign o_valid           = r_valid;
    assign o_entry.data_byte = r_data_byte;
    assign o_entry.blank     = r_blank;
    assign o_entry.sym       = r_sym;
    assign o_entry.key       = r_key;

endmodule

// ----- rtl/ac62_queue.sv -----
// Short queue of classified items between front and back end.
// Depends on ac62_pkg for the entry type and depth.

module ac62_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  ac62_pkg::t_entry          i_entry,
    input  logic                      i_pop,
    output logic                      o_valid,
    output ac62_pkg::t_entry          o_entry,
    output logic [ac62_pkg::QCW-1:0]  o_count
);
    import ac62_pkg::*;

    t_entry         r_slots [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_count;
    logic           do_pop;

    assign do_pop = i_pop && (r_count != '0);

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr] <= i_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_count <= r_count + QCW'(i_push) - QCW'(do_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_entry = r_slots[r_rd];
    assign o_count = r_count;

endmodule

// ----- rtl/ac62_back.sv -----
// Back end: applies the mod-62 key shift to a classified item and holds the
// result byte in the output register. Depends on ac62_pkg.

module ac62_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ac62_pkg::t_dir    i_direction,
    input  logic              i_valid,
    output logic              o_ready,
    input  ac62_pkg::t_entry  i_entry,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_data_byte
);
    import ac62_pkg::*;

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       take;
    logic [6:0] shift;
    logic [6:0] sum;
    logic [6:0] wrapped;
    logic [7:0] result;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    // key word mod 62, then shifted index mod 62
    always_comb begin
        if (i_entry.key >= ALPHA_TWICE) begin
            shift = i_entry.key - ALPHA_TWICE;
        end else if (i_entry.key >= ALPHA_SIZE) begin
            shift = i_entry.key - ALPHA_SIZE;
        end else begin
            shift = i_entry.key;
        end
        unique case (i_direction)
            DIR_ENCRYPT: sum = 7'(i_entry.sym) + shift;
            DIR_DECRYPT: sum = 7'(i_entry.sym) + ALPHA_SIZE - shift;
        endcase
        wrapped = (sum >= ALPHA_SIZE) ? (sum - ALPHA_SIZE) : sum;
        result  = i_entry.blank ? i_entry.data_byte : f_sym_char(wrapped[5:0]);
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_data_byte <= result;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_data_byte;

endmodule

// ----- rtl/alnum62_vigenere_cipher_core.sv -----
// Vigenere cipher over the 62-symbol alphabet a-z, A-Z, 0-9, one byte per cycle
// unless stalled. Items enter on a stream input: tuser = 0 loads a key word into
// the key table slot key_index and returns the key position to zero; tuser = 1
// carries a data byte that comes back on the stream output shifted by the current
// key word, whitespace unchanged. The block takes one item every cycle while the
// queue has room; a data byte passes through the front register with the key
// table read, the queue and the output register. A four-entry queue between the
// classifying front end and the shifting back end absorbs output stalls, so input
// stalls only once that queue and the item in flight fill it. Key loads give no
// output. Write direction and key_length only while the block is idle; key table
// words read before they are written give undefined output.

module alnum62_vigenere_cipher_core #(
    parameter int unsigned KEY_DEPTH = ac62_pkg::KEY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // key_index[5:0], key_value[12:6], in_byte[20:13]
    input  logic        i_s_axis_tuser,   // kind[0]
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // out_byte[7:0]
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import ac62_pkg::*;

    t_cfg           r_cfg;
    t_kind          in_kind;
    logic           w_front_valid;
    t_entry         w_front_entry;
    logic           w_q_valid;
    t_entry         w_q_entry;
    logic [QCW-1:0] w_q_count;
    logic           w_back_ready;

    assign in_kind     = t_kind'(i_s_axis_tuser);
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction  <= DIR_ENCRYPT;
            r_cfg.key_length <= 7'd1;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_DIRECTION:  r_cfg.direction  <= t_dir'(i_cfg_data[0]);
                REG_KEY_LENGTH: r_cfg.key_length <= i_cfg_data;
            endcase
        end
    end

    // accept, key table, classification
    ac62_front #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_kind      (in_kind),
        .i_key_index (i_s_axis_tdata[5:0]),
        .i_key_value (i_s_axis_tdata[12:6]),
        .i_in_byte   (i_s_axis_tdata[20:13]),
        .i_q_count   (w_q_count),
        .o_valid     (w_front_valid),
        .o_entry     (w_front_entry)
    );

    // decoupling queue
    ac62_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_entry (w_front_entry),
        .i_pop   (w_back_ready),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .o_count (w_q_count)
    );

    // shift and output register
    ac62_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_direction (r_cfg.direction),
        .i_valid     (w_q_valid),
        .o_ready     (w_back_ready),
        .i_entry     (w_q_entry),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data_byte (o_m_axis_tdata)
    );

`ifndef SYNTH
    // queue plus in-flight item never exceed the queue
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(w_q_count) + 32'(w_front_valid)) <= QUEUE_DEPTH)
        else $error("queue overcommitted");

    // an accepted data byte enters the front register
    a_data_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && in_kind == KIND_DATA) |=> w_front_valid)
        else $error("data byte lost in front end");

    // key loads never reach the back end
    a_key_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && in_kind == KIND_KEY) |=> !w_front_valid)
        else $error("key load produced a data entry");

    // a new result comes only from a queued item
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_q_valid))
        else $error("result without queued item");
`endif

endmodule
